// ===== design/tbte_pkg.sv =====
// Shared types and constants of the two-wire transaction engine.
package tbte_pkg;

  localparam logic [1:0] REQ_PLAIN = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] PULSE_NONE     = 2'd0;
  localparam logic [1:0] PULSE_LOW_HIGH = 2'd1;
  localparam logic [1:0] PULSE_HIGH_LOW = 2'd2;

  localparam logic [5:0] WRITE_LAST        = 6'd32;
  localparam logic [5:0] READ_SEND_LAST    = 6'd24;
  localparam logic [5:0] READ_TURN         = 6'd25;
  localparam logic [5:0] READ_FIRST_SAMPLE = 6'd26;
  localparam logic [5:0] READ_LAST         = 6'd33;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        sample;
  } item_t;

  typedef struct packed {
    logic       io_level;
    logic       io_drive;
    logic [1:0] clk_pulse;
    logic [7:0] read_byte;
    logic       read_done;
    logic       busy_res;
    logic       rejected;
  } result_t;

endpackage

// ===== design/tbte_front.sv =====
// Front end: classify the request and pack the word to send.
module tbte_front (
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_cmd_byte,
  input  logic [15:0]         in_target_address,
  input  logic [7:0]          in_write_byte,
  input  logic                in_io_in,
  output tbte_pkg::item_t     item
);

  always_comb begin
    item.sample = in_io_in;
    case (in_req_type)
      tbte_pkg::REQ_WRITE: begin
        item.kind = tbte_pkg::MODE_WRITE;
        item.word = {in_cmd_byte, in_target_address, in_write_byte};
      end
      tbte_pkg::REQ_READ: begin
        item.kind = tbte_pkg::MODE_READ;
        item.word = {8'h00, in_cmd_byte, in_target_address};
      end
      default: begin
        item.kind = tbte_pkg::MODE_IDLE;
        item.word = {8'h00, in_cmd_byte, in_target_address};
      end
    endcase
  end

endmodule

// ===== design/tbte_queue.sv =====
// Two-entry queue between the front end and the bit engine.
module tbte_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbte_pkg::item_t push_item,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output tbte_pkg::item_t pop_item
);

  tbte_pkg::item_t mem_r [tbte_pkg::QUEUE_DEPTH];
  logic [tbte_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tbte_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tbte_pkg::QUEUE_AW:0]   count_r, count_nxt;

  assign not_full  = (count_r != tbte_pkg::QUEUE_AW'(0) + (tbte_pkg::QUEUE_AW+1)'(tbte_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/tbte_back.sv =====
// Bit engine: run the transaction sequence and hold the result register.
module tbte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  tbte_pkg::item_t    item,
  output logic               item_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output tbte_pkg::result_t  res
);

  logic [1:0]  mode_r, mode_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        drv_r, drv_nxt;
  logic        out_valid_r, out_valid_nxt;
  tbte_pkg::result_t out_r, out_nxt;

  logic [1:0]  mode_eff;
  logic [5:0]  cnt_eff;
  logic [31:0] shift_eff;
  logic [7:0]  rx_eff;
  logic [5:0]  c_rel;
  logic        start;
  logic        last;

  assign item_pop  = item_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    start     = (item.kind != tbte_pkg::MODE_IDLE);
    mode_eff  = mode_r;
    cnt_eff   = cnt_r;
    shift_eff = shift_r;
    rx_eff    = rx_r;
    out_nxt   = '0;
    out_nxt.io_drive = drv_r;
    last      = 1'b0;
    c_rel     = cnt_eff - tbte_pkg::READ_FIRST_SAMPLE;

    if (start) begin
      if (mode_r != tbte_pkg::MODE_IDLE) begin
        out_nxt.rejected = 1'b1;
      end else begin
        mode_eff  = item.kind;
        cnt_eff   = '0;
        shift_eff = item.word;
        rx_eff    = '0;
      end
    end

    shift_nxt = shift_eff;
    rx_nxt    = rx_eff;
    drv_nxt   = drv_r;
    c_rel     = cnt_eff - tbte_pkg::READ_FIRST_SAMPLE;

    if (mode_eff != tbte_pkg::MODE_IDLE) begin
      out_nxt.busy_res = 1'b1;
      if (cnt_eff == '0) begin
        out_nxt.io_level  = 1'b1;
        out_nxt.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        drv_nxt           = 1'b1;
      end else if ((mode_eff == tbte_pkg::MODE_WRITE && cnt_eff <= tbte_pkg::WRITE_LAST) ||
                   (mode_eff == tbte_pkg::MODE_READ && cnt_eff <= tbte_pkg::READ_SEND_LAST)) begin
        out_nxt.io_level  = shift_eff[0];
        out_nxt.clk_pulse = tbte_pkg::PULSE_HIGH_LOW;
        shift_nxt         = {1'b0, shift_eff[31:1]};
        last = (mode_eff == tbte_pkg::MODE_WRITE) && (cnt_eff == tbte_pkg::WRITE_LAST);
      end else if (mode_eff == tbte_pkg::MODE_READ && cnt_eff == tbte_pkg::READ_TURN) begin
        out_nxt.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        drv_nxt           = 1'b0;
      end else if (mode_eff == tbte_pkg::MODE_READ && cnt_eff >= tbte_pkg::READ_FIRST_SAMPLE &&
                   cnt_eff <= tbte_pkg::READ_LAST) begin
        out_nxt.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        rx_nxt = rx_eff | (8'(item.sample) << c_rel[2:0]);
        if (cnt_eff == tbte_pkg::READ_LAST) begin
          out_nxt.read_done = 1'b1;
          out_nxt.read_byte = rx_nxt;
          last = 1'b1;
        end
      end else begin
        last = 1'b1;
      end
      if (last) begin
        mode_nxt = tbte_pkg::MODE_IDLE;
        cnt_nxt  = '0;
      end else begin
        mode_nxt = mode_eff;
        cnt_nxt  = cnt_eff + 1'b1;
      end
    end else begin
      mode_nxt = mode_eff;
      cnt_nxt  = cnt_eff;
    end

    if (item_pop) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tbte_pkg::MODE_IDLE;
      cnt_r       <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      drv_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_pop) begin
        mode_r  <= mode_nxt;
        cnt_r   <= cnt_nxt;
        shift_r <= shift_nxt;
        rx_r    <= rx_nxt;
        drv_r   <= drv_nxt;
      end
    end
  end

endmodule

// ===== design/two_wire_bitbang_transaction_engine.sv =====
// Top level of the two-wire bit-banged serial master.
//
// Input channel (in_*): one transfer is one bit period. in_req_type 1 starts a
// write, 2 starts a read, anything else is a plain period; in_io_in is the
// level sampled on the data line in that period.
// Output channel (out_*): exactly one transfer per input transfer, in order,
// giving the line level, direction, clock pulse kind, the received byte with
// read_done, busy_res and rejected (a start request while busy).
// A write takes 33 periods, a read 34 periods.
// Path: an accepted transfer is written into the two-entry queue, then moves
// into the result register, which drives the output. Throughput: one transfer
// per cycle while out_ready holds; the bit engine updates its state once per
// period, so one period per cycle is the sustained rate.
// Reset: no transaction in progress, data line set as output, queue and
// result register empty.
// Receiver stall: the result register holds; the queue absorbs up to two
// more transfers, after which in_ready drops until out_ready returns.
module two_wire_bitbang_transaction_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_cmd_byte,
  input  logic [15:0] in_target_address,
  input  logic [7:0]  in_write_byte,
  input  logic        in_io_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_io_level,
  output logic        out_io_drive,
  output logic [1:0]  out_clk_pulse,
  output logic [7:0]  out_read_byte,
  output logic        out_read_done,
  output logic        out_busy_res,
  output logic        out_rejected
);

  tbte_pkg::item_t   front_item;
  tbte_pkg::item_t   queue_item;
  tbte_pkg::result_t res;
  logic              queue_not_full;
  logic              queue_not_empty;
  logic              queue_pop;

  assign in_ready = queue_not_full;

  tbte_front u_front (
    .in_req_type       (in_req_type),
    .in_cmd_byte       (in_cmd_byte),
    .in_target_address (in_target_address),
    .in_write_byte     (in_write_byte),
    .in_io_in          (in_io_in),
    .item              (front_item)
  );

  tbte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && queue_not_full),
    .push_item (front_item),
    .not_full  (queue_not_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_item  (queue_item)
  );

  tbte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (queue_not_empty),
    .item       (queue_item),
    .item_pop   (queue_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_io_level  = res.io_level;
  assign out_io_drive  = res.io_drive;
  assign out_clk_pulse = res.clk_pulse;
  assign out_read_byte = res.read_byte;
  assign out_read_done = res.read_done;
  assign out_busy_res  = res.busy_res;
  assign out_rejected  = res.rejected;

endmodule

// ===== design/tbte_checker.sv =====
// Port-level checks of the two-wire transaction engine, bound to the top level.
module tbte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_io_level,
  input logic       out_io_drive,
  input logic [1:0] out_clk_pulse,
  input logic       out_read_done,
  input logic       out_busy_res,
  input logic       out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_clk_pulse == tbte_pkg::PULSE_NONE && !out_io_level)
    else $error("idle period shows activity");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("rejection outside a transaction");

  a_done_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_done |-> out_busy_res && !out_io_drive && !out_io_level &&
      out_clk_pulse == tbte_pkg::PULSE_LOW_HIGH)
    else $error("read completion with wrong line state");

endmodule

bind two_wire_bitbang_transaction_engine tbte_checker u_tbte_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_io_level  (out_io_level),
  .out_io_drive  (out_io_drive),
  .out_clk_pulse (out_clk_pulse),
  .out_read_done (out_read_done),
  .out_busy_res  (out_busy_res),
  .out_rejected  (out_rejected)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the two-wire bit-banged transaction engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PERIODS = 550;
  localparam int STALL_LIMIT = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int WRITE_SPAN = 33;
  localparam int READ_SPAN = 34;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]        req;
    logic [7:0]        cmd;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic              io;
    logic              checked;
    tbte_pkg::result_t activity;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_req_type = tbte_pkg::REQ_PLAIN;
  logic [7:0]  in_cmd_byte = '0;
  logic [15:0] in_target_address = '0;
  logic [7:0]  in_write_byte = '0;
  logic        in_io_in = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_io_level;
  logic        out_io_drive;
  logic [1:0]  out_clk_pulse;
  logic [7:0]  out_read_byte;
  logic        out_read_done;
  logic        out_busy_res;
  logic        out_rejected;

  two_wire_bitbang_transaction_engine DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_cmd_byte       (in_cmd_byte),
    .in_target_address (in_target_address),
    .in_write_byte     (in_write_byte),
    .in_io_in          (in_io_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_io_level      (out_io_level),
    .out_io_drive      (out_io_drive),
    .out_clk_pulse     (out_clk_pulse),
    .out_read_byte     (out_read_byte),
    .out_read_done     (out_read_done),
    .out_busy_res      (out_busy_res),
    .out_rejected      (out_rejected)
  );

  logic [1:0]  link_mode = tbte_pkg::MODE_IDLE;
  logic [5:0]  link_period = '0;
  logic [31:0] tx_bits = '0;
  logic [7:0]  rx_bits = '0;
  logic        line_out = 1'b1;

  tbte_pkg::result_t pin_activity_q[$];
  logic              row_checked = 1'b0;
  tbte_pkg::result_t row_activity = '0;
  int                periods_sent = 0;
  int                periods_seen = 0;
  int                quiet_cycles = 0;
  int                errors = 0;
  bit                send_calm = 1'b0;
  bit                take_calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic tbte_pkg::result_t pin_activity(input logic [1:0] req,
                                                     input logic [7:0] cmd,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data,
                                                     input logic io);
    tbte_pkg::result_t r;
    logic finish;
    logic [5:0] slot;
    r = '0;
    finish = 1'b0;
    r.io_drive = line_out;
    if (req == tbte_pkg::REQ_WRITE || req == tbte_pkg::REQ_READ) begin
      if (link_mode != tbte_pkg::MODE_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        link_period = '0;
        rx_bits = '0;
        if (req == tbte_pkg::REQ_WRITE) begin
          link_mode = tbte_pkg::MODE_WRITE;
          tx_bits = {cmd, addr, data};
        end else begin
          link_mode = tbte_pkg::MODE_READ;
          tx_bits = {8'h00, cmd, addr};
        end
      end
    end
    if (link_mode != tbte_pkg::MODE_IDLE) begin
      r.busy_res = 1'b1;
      if (link_period == 6'd0) begin
        r.io_level = 1'b1;
        r.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        line_out = 1'b1;
      end else if ((link_mode == tbte_pkg::MODE_WRITE &&
                    link_period <= tbte_pkg::WRITE_LAST) ||
                   (link_mode == tbte_pkg::MODE_READ &&
                    link_period <= tbte_pkg::READ_SEND_LAST)) begin
        r.io_level = tx_bits[0];
        tx_bits = tx_bits >> 1;
        r.clk_pulse = tbte_pkg::PULSE_HIGH_LOW;
        finish = (link_mode == tbte_pkg::MODE_WRITE && link_period == tbte_pkg::WRITE_LAST);
      end else if (link_mode == tbte_pkg::MODE_READ && link_period == tbte_pkg::READ_TURN) begin
        r.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        line_out = 1'b0;
      end else if (link_mode == tbte_pkg::MODE_READ &&
                   link_period >= tbte_pkg::READ_FIRST_SAMPLE &&
                   link_period <= tbte_pkg::READ_LAST) begin
        r.clk_pulse = tbte_pkg::PULSE_LOW_HIGH;
        slot = link_period - tbte_pkg::READ_FIRST_SAMPLE;
        rx_bits[slot[2:0]] = rx_bits[slot[2:0]] | io;
        if (link_period == tbte_pkg::READ_LAST) begin
          r.read_done = 1'b1;
          r.read_byte = rx_bits;
          finish = 1'b1;
        end
      end else begin
        finish = 1'b1;
      end
      if (finish) begin
        link_mode = tbte_pkg::MODE_IDLE;
        link_period = '0;
      end else begin
        link_period = link_period + 6'd1;
      end
    end
    return r;
  endfunction

  function automatic tbte_pkg::result_t pins(input logic level, input logic drive,
                                             input logic [1:0] pulse,
                                             input logic busy, input logic rej);
    tbte_pkg::result_t r;
    r = '0;
    r.io_level = level;
    r.io_drive = drive;
    r.clk_pulse = pulse;
    r.busy_res = busy;
    r.rejected = rej;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [1:0] req, input logic [7:0] cmd,
                                    input logic [15:0] addr, input logic [7:0] data,
                                    input logic io, input logic checked,
                                    input tbte_pkg::result_t activity);
    stim_row_t s;
    s.req = req;
    s.cmd = cmd;
    s.addr = addr;
    s.data = data;
    s.io = io;
    s.checked = checked;
    s.activity = activity;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tbte_pkg::result_t want;
    logic took, gave;
    took = in_valid && in_ready;
    gave = out_valid && out_ready;
    if (rst_n) begin
      if (took) begin
        want = pin_activity(in_req_type, in_cmd_byte, in_target_address, in_write_byte,
                            in_io_in);
        pin_activity_q.push_back(row_checked ? row_activity : want);
      end
      if (gave) begin
        periods_seen++;
        if (pin_activity_q.size() == 0) begin
          errors++;
          $error("result transfer with nothing expected");
        end else begin
          want = pin_activity_q.pop_front();
          check_field("io_level", want.io_level, out_io_level);
          check_field("io_drive", want.io_drive, out_io_drive);
          check_field("clk_pulse", want.clk_pulse, out_clk_pulse);
          check_field("read_byte", want.read_byte, out_read_byte);
          check_field("read_done", want.read_done, out_read_done);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("rejected", want.rejected, out_rejected);
        end
      end
      quiet_cycles = (took || gave) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("two_wire_bitbang_transaction_engine regression: fail");
    $finish;
  end

  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_period(input logic [1:0] req, input logic [7:0] cmd,
                             input logic [15:0] addr, input logic [7:0] data, input logic io,
                             input logic checked, input tbte_pkg::result_t activity);
    int gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_cmd_byte <= cmd;
    in_target_address <= addr;
    in_write_byte <= data;
    in_io_in <= io;
    row_checked <= checked;
    row_activity <= activity;
    do @(posedge clk); while (in_ready !== 1'b1);
    periods_sent++;
  endtask

  task automatic send_random(input logic [1:0] req);
    send_period(req, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (periods_seen < periods_sent);
  endtask

  initial begin
    stim_row_t directed[$];
    int pick;
    int span;
    logic [1:0] kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    directed.push_back(row(tbte_pkg::REQ_PLAIN, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1,
                           pins(1'b0, 1'b1, tbte_pkg::PULSE_NONE, 1'b0, 1'b0)));
    directed.push_back(row(REQ_RESERVED, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
                           pins(1'b0, 1'b1, tbte_pkg::PULSE_NONE, 1'b0, 1'b0)));
    directed.push_back(row(tbte_pkg::REQ_WRITE, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1,
                           pins(1'b1, 1'b1, tbte_pkg::PULSE_LOW_HIGH, 1'b1, 1'b0)));
    directed.push_back(row(tbte_pkg::REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b1,
                           pins(1'b1, 1'b1, tbte_pkg::PULSE_HIGH_LOW, 1'b1, 1'b1)));
    directed.push_back(row(tbte_pkg::REQ_WRITE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1,
                           pins(1'b1, 1'b1, tbte_pkg::PULSE_HIGH_LOW, 1'b1, 1'b1)));
    directed.push_back(row(REQ_RESERVED, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, '0));
    directed.push_back(row(tbte_pkg::REQ_PLAIN, 8'hA5, 16'h5A5A, 8'hC3, 1'b0, 1'b0, '0));
    directed.push_back(row(tbte_pkg::REQ_READ, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, '0));
    directed.push_back(row(tbte_pkg::REQ_PLAIN, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, '0));
    directed.push_back(row(tbte_pkg::REQ_PLAIN, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, '0));
    foreach (directed[i]) begin
      send_period(directed[i].req, directed[i].cmd, directed[i].addr, directed[i].data,
                  directed[i].io, directed[i].checked, directed[i].activity);
    end
    wait_drained();
    while (periods_sent < N_PERIODS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        kind = (pick < 4) ? tbte_pkg::REQ_WRITE : tbte_pkg::REQ_READ;
        span = (kind == tbte_pkg::REQ_WRITE) ? WRITE_SPAN : READ_SPAN;
        send_random(kind);
        for (int j = 1; j < span; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_random(2'($urandom_range(tbte_pkg::REQ_WRITE, REQ_RESERVED)));
          end else begin
            send_random(tbte_pkg::REQ_PLAIN);
          end
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_random($urandom_range(0, 1) ? REQ_RESERVED : tbte_pkg::REQ_PLAIN);
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("two_wire_bitbang_transaction_engine regression: pass");
    end else begin
      $display("two_wire_bitbang_transaction_engine regression: fail");
    end
    $finish;
  end

endmodule
